/* hdl/kpm_pkg.sv */
// Shared types and constants for the keyword prefix matcher.
`timescale 1ns / 1ps

package kpm_pkg;

   localparam int SLOT_W  = 4;
   localparam int POS_W   = 5;
   localparam int CHAR_W  = 8;
   localparam int COUNT_W = 5;
   localparam int INDEX_W = 4;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef struct packed {
      op_type             op;
      logic               in_range;
      logic [SLOT_W-1:0]  slot;
      logic [POS_W-1:0]   pos;
      logic [CHAR_W-1:0]  ch;
      logic               last;
   } item_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COMPARE
   } back_state_type;

endpackage

/* hdl/kpm_channels.sv */
// Channel interfaces for requests, responses and the count register write.
`timescale 1ns / 1ps

interface kpm_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [3:0] keyword_slot;
   logic [4:0] char_pos;
   logic [7:0] char_value;
   logic       is_last;

   modport source (output valid, op, keyword_slot, char_pos, char_value, is_last,
                   input ready);
   modport sink   (input valid, op, keyword_slot, char_pos, char_value, is_last,
                   output ready);
endinterface

interface kpm_rsp_if;
   logic       valid;
   logic       ready;
   logic       found;
   logic [3:0] match_index;

   modport source (output valid, found, match_index, input ready);
   modport sink   (input valid, found, match_index, output ready);
endinterface

interface kpm_csr_if;
   logic       valid;
   logic       ready;
   logic [4:0] keyword_count;

   modport source (output valid, keyword_count, input ready);
   modport sink   (input valid, keyword_count, output ready);
endinterface

/* hdl/kpm_ram.sv */
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps

module kpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/kpm_front.sv */
// Front end: accepts request transfers, classifies them and queues them.
`timescale 1ns / 1ps

module kpm_front
   import kpm_pkg::*;
#(
   parameter int NUM_KEYWORDS    = 16,
   parameter int MAX_KEYWORD_LEN = 32
) (
   input  logic      clock,
   input  logic      reset,
   kpm_req_if.sink   req_port,
   input  logic      clearing,
   input  logic      pop,
   output logic      item_valid,
   output item_type  item
);

   localparam int QUEUE_DEPTH = 2;

   item_type       entry_ff [QUEUE_DEPTH];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           push;
   item_type       new_item;

   always_comb begin
      new_item.op       = op_type'(req_port.op);
      new_item.in_range = (32'(req_port.keyword_slot) < NUM_KEYWORDS) &&
                          (32'(req_port.char_pos) < MAX_KEYWORD_LEN);
      new_item.slot     = req_port.keyword_slot;
      new_item.pos      = req_port.char_pos;
      new_item.ch       = req_port.char_value;
      new_item.last     = req_port.is_last;
   end

   assign req_port.ready = (count_ff != 2'(QUEUE_DEPTH)) && !clearing;
   assign push           = req_port.valid && req_port.ready;
   assign item_valid     = (count_ff != 2'd0);
   assign item           = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

/* hdl/kpm_back.sv */
// Back end: keyword store lanes, match vector and response register.
`timescale 1ns / 1ps

module kpm_back
   import kpm_pkg::*;
#(
   parameter int NUM_KEYWORDS    = 16,
   parameter int MAX_KEYWORD_LEN = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  item_type           item,
   input  logic [COUNT_W-1:0] keyword_count,
   output logic               pop,
   output logic               clearing,
   kpm_rsp_if.source          rsp_port
);

   localparam int ADDR_W = $clog2(MAX_KEYWORD_LEN);
   localparam int QPOS_W = $clog2(MAX_KEYWORD_LEN + 1);

   back_state_type          state_ff, state_in;
   logic [ADDR_W-1:0]       clr_addr_ff, clr_addr_in;
   logic [QPOS_W-1:0]       qpos_ff, qpos_in;
   logic [NUM_KEYWORDS-1:0] match_ff, match_in;
   logic [CHAR_W-1:0]       q_ch_ff, q_ch_in;
   logic                    q_last_ff, q_last_in;
   logic                    q_inrange_ff, q_inrange_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [INDEX_W-1:0]      rsp_index_ff, rsp_index_in;

   logic [CHAR_W-1:0]       lane_data [NUM_KEYWORDS];
   logic [NUM_KEYWORDS-1:0] lane_we;
   logic [NUM_KEYWORDS-1:0] eq;
   logic [NUM_KEYWORDS-1:0] new_match;
   logic [NUM_KEYWORDS-1:0] hit;
   logic [ADDR_W-1:0]       wr_addr;
   logic [CHAR_W-1:0]       wr_data;
   logic                    rd_en;
   logic                    qpos_live;
   logic                    load_now;
   logic                    can_emit;
   logic [INDEX_W-1:0]      first_index;

   assign qpos_live = qpos_ff < QPOS_W'(MAX_KEYWORD_LEN);
   assign clearing  = (state_ff == ST_CLEAR);
   assign pop       = (state_ff == ST_IDLE) && item_valid;
   assign load_now  = pop && (item.op == OP_LOAD) && item.in_range;
   assign rd_en     = pop && (item.op == OP_QUERY) && qpos_live;
   assign wr_addr   = clearing ? clr_addr_ff : ADDR_W'(item.pos);
   assign wr_data   = clearing ? '0 : item.ch;

   for (genvar k = 0; k < NUM_KEYWORDS; k++) begin : g_lane
      assign lane_we[k] = clearing || (load_now && (32'(item.slot) == k));
      assign eq[k]      = q_inrange_ff && (lane_data[k] == q_ch_ff);
      assign hit[k]     = new_match[k] && (32'(keyword_count) > k);

      kpm_ram #(
         .WIDTH (CHAR_W),
         .DEPTH (MAX_KEYWORD_LEN)
      ) u_lane_ram (
         .clock   (clock),
         .wr_en   (lane_we[k]),
         .wr_addr (wr_addr),
         .wr_data (wr_data),
         .rd_en   (rd_en),
         .rd_addr (qpos_ff[ADDR_W-1:0]),
         .rd_data (lane_data[k])
      );
   end

   assign new_match = match_ff & eq;

   always_comb begin
      first_index = '0;
      for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
         if (hit[k]) begin
            first_index = INDEX_W'(k);
         end
      end
   end

   assign can_emit = !rsp_valid_ff || rsp_port.ready;

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      qpos_in      = qpos_ff;
      match_in     = match_ff;
      q_ch_in      = q_ch_ff;
      q_last_in    = q_last_ff;
      q_inrange_in = q_inrange_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      rsp_found_in = rsp_found_ff;
      rsp_index_in = rsp_index_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(MAX_KEYWORD_LEN - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (pop && (item.op == OP_QUERY)) begin
               q_ch_in      = item.ch;
               q_last_in    = item.last;
               q_inrange_in = qpos_live;
               state_in     = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            if (!q_last_ff) begin
               match_in = new_match;
               qpos_in  = qpos_live ? qpos_ff + QPOS_W'(1) : qpos_ff;
               state_in = ST_IDLE;
            end else if (can_emit) begin
               match_in     = '1;
               qpos_in      = '0;
               rsp_valid_in = 1'b1;
               rsp_found_in = |hit;
               rsp_index_in = first_index;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         qpos_ff      <= '0;
         match_ff     <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         qpos_ff      <= qpos_in;
         match_ff     <= match_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ch_ff      <= q_ch_in;
      q_last_ff    <= q_last_in;
      q_inrange_ff <= q_inrange_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.found       = rsp_found_ff;
   assign rsp_port.match_index = rsp_index_ff;

endmodule

/* hdl/keyword_prefix_matcher.sv */
// Top level of the keyword prefix matcher.
`timescale 1ns / 1ps

// The request channel carries load transfers, which write one byte of a keyword
// slot, and query transfers, which stream the bytes of a sequence to be matched.
// The response channel carries one transfer per query byte marked last: whether
// a keyword among the first keyword_count slots starts with the sequence, and
// the lowest such slot. The csr channel writes keyword_count and is always ready.
// An in-range load is written to the keyword store as it leaves the queue, and a query
// byte first reads the keyword store row at the current position and then is compared.
// A two-entry queue separates the request side from the back end.
// After reset the keyword store is cleared one position per cycle, and requests
// are held off until that is done.
// When the receiver stalls, the response register holds its transfer and the
// back end waits on the next last byte, while the queue takes requests until
// both of its entries are full.
module keyword_prefix_matcher
   import kpm_pkg::*;
#(
   parameter int NUM_KEYWORDS    = 16,
   parameter int MAX_KEYWORD_LEN = 32
) (
   input  logic       clock,
   input  logic       reset,
   kpm_req_if.sink    req_port,
   kpm_rsp_if.source  rsp_port,
   kpm_csr_if.sink    csr_port
);

   logic [COUNT_W-1:0] keyword_count_ff, keyword_count_in;
   logic               clearing;
   logic               pop;
   logic               item_valid;
   item_type           item;

   assign csr_port.ready   = 1'b1;
   assign keyword_count_in = (csr_port.valid && csr_port.ready) ?
                             csr_port.keyword_count : keyword_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         keyword_count_ff <= '0;
      end else begin
         keyword_count_ff <= keyword_count_in;
      end
   end

   kpm_front #(
      .NUM_KEYWORDS    (NUM_KEYWORDS),
      .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_port   (req_port),
      .clearing   (clearing),
      .pop        (pop),
      .item_valid (item_valid),
      .item       (item)
   );

   kpm_back #(
      .NUM_KEYWORDS    (NUM_KEYWORDS),
      .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (item_valid),
      .item          (item),
      .keyword_count (keyword_count_ff),
      .pop           (pop),
      .clearing      (clearing),
      .rsp_port      (rsp_port)
   );

   a_no_accept_while_clearing: assert property (
      @(posedge clock) disable iff (reset) clearing |-> !req_port.ready
   ) else $error("Request ready during the store clear.");

   a_no_response_while_clearing: assert property (
      @(posedge clock) disable iff (reset) clearing |-> !rsp_port.valid
   ) else $error("Response valid during the store clear.");

   a_index_zero_when_not_found: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_port.valid && !rsp_port.found) |-> (rsp_port.match_index == '0)
   ) else $error("Nonzero match index on a response without a match.");

   a_no_pop_while_clearing: assert property (
      @(posedge clock) disable iff (reset) clearing |-> !pop
   ) else $error("Queue entry taken during the store clear.");

endmodule

/* verif/tb.sv */
// Testbench for the keyword prefix matcher: random and directed loads, queries and count writes.
`timescale 1ns / 1ps

module tb
   import kpm_pkg::*;
();

   localparam int NUM_KW  = 16;
   localparam int KW_LEN  = 32;
   localparam int LIMIT   = 500000;
   localparam int HOLD_CYCLES = 300;
   localparam logic [7:0] BASE_CHAR = 8'h41;

   typedef struct {
      op_type             op;
      logic [SLOT_W-1:0]  slot;
      logic [POS_W-1:0]   pos;
      logic [CHAR_W-1:0]  ch;
      logic               last;
   } req_item_type;

   typedef struct {
      logic               found;
      logic [INDEX_W-1:0] index;
   } match_type;

   logic clock;
   logic reset;

   kpm_req_if req_bus ();
   kpm_rsp_if rsp_bus ();
   kpm_csr_if csr_bus ();

   keyword_prefix_matcher u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   req_item_type req_backlog[$];
   match_type    pending_matches[$];

   logic [7:0]         kw_table [NUM_KW][KW_LEN];
   logic [NUM_KW-1:0]  still_alive;
   int                 query_pos;
   logic [COUNT_W-1:0] active_count;

   logic [7:0] gen_table [NUM_KW][KW_LEN];
   int         gen_len [NUM_KW];

   int pushed_count;
   int accepted_count;
   int error_count;
   int send_idle_pct;
   int rsp_stall_pct;
   int hold_asked;
   int hold_served;
   int hold_left;
   int cycle_count;

   req_item_type on_bus;
   req_item_type next_item;
   match_type    want;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void advance_match(input req_item_type r);
      int k;
      int limit;
      match_type m;
      if (r.op == OP_LOAD) begin
         kw_table[r.slot][r.pos] = r.ch;
         return;
      end
      for (k = 0; k < NUM_KW; k++) begin
         if (query_pos >= KW_LEN || kw_table[k][query_pos] != r.ch) begin
            still_alive[k] = 1'b0;
         end
      end
      if (query_pos < KW_LEN) begin
         query_pos++;
      end
      if (!r.last) begin
         return;
      end
      limit = (active_count > NUM_KW) ? NUM_KW : active_count;
      m.found = 1'b0;
      m.index = '0;
      for (k = limit - 1; k >= 0; k--) begin
         if (still_alive[k]) begin
            m.found = 1'b1;
            m.index = INDEX_W'(k);
         end
      end
      pending_matches.push_back(m);
      still_alive = '1;
      query_pos = 0;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         foreach (kw_table[s, p]) kw_table[s][p] = 8'h00;
         still_alive = '1;
         query_pos = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            on_bus.op   = op_type'(req_bus.op);
            on_bus.slot = req_bus.keyword_slot;
            on_bus.pos  = req_bus.char_pos;
            on_bus.ch   = req_bus.char_value;
            on_bus.last = req_bus.is_last;
            advance_match(on_bus);
            accepted_count++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (req_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               next_item = req_backlog.pop_front();
               req_bus.valid        <= 1'b1;
               req_bus.op           <= next_item.op;
               req_bus.keyword_slot <= next_item.slot;
               req_bus.char_pos     <= next_item.pos;
               req_bus.char_value   <= next_item.ch;
               req_bus.is_last      <= next_item.last;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_matches.size() == 0) begin
               $display("%0t: unexpected transfer, found %0b index %0d", $time,
                        rsp_bus.found, rsp_bus.match_index);
               error_count++;
            end else begin
               want = pending_matches.pop_front();
               if (rsp_bus.found !== want.found) begin
                  $display("%0t: found expected %0b actual %0b", $time,
                           want.found, rsp_bus.found);
                  error_count++;
               end
               if (rsp_bus.match_index !== want.index) begin
                  $display("%0t: match_index expected %0d actual %0d", $time,
                           want.index, rsp_bus.match_index);
                  error_count++;
               end
            end
         end
         if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99, 0) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("FAIL keyword_prefix_matcher");
         $finish;
      end
   end

   task automatic push_req(input op_type op, input logic [3:0] slot, input logic [4:0] pos,
                           input logic [7:0] ch, input logic last);
      req_item_type r;
      r.op = op;
      r.slot = slot;
      r.pos = pos;
      r.ch = ch;
      r.last = last;
      if (op == OP_LOAD) begin
         gen_table[slot][pos] = ch;
      end
      req_backlog.push_back(r);
      pushed_count++;
   endtask

   task automatic settle();
      while (accepted_count != pushed_count || pending_matches.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
   endtask

   task automatic write_count(input logic [COUNT_W-1:0] value);
      csr_bus.valid         <= 1'b1;
      csr_bus.keyword_count <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      active_count = value;
   endtask

   task automatic queue_keyword(input int slot);
      int len;
      int p;
      logic [7:0] ch;
      len = ($urandom_range(9, 0) == 0) ? $urandom_range(KW_LEN, 1) : $urandom_range(6, 1);
      for (p = 0; p < len; p++) begin
         ch = ($urandom_range(3, 0) == 0) ? 8'($urandom) : BASE_CHAR + 8'($urandom_range(2, 0));
         push_req(OP_LOAD, 4'(slot), 5'(p), ch, 1'($urandom));
      end
      if (len < KW_LEN) begin
         push_req(OP_LOAD, 4'(slot), 5'(len), 8'h00, 1'($urandom));
      end
      gen_len[slot] = len;
   endtask

   // Most sequences follow a stored keyword, some with one bit flipped, some are noise,
   // and a few run past the end of a keyword slot.
   task automatic queue_query();
      int k;
      int n;
      int kind;
      int flip_at;
      int i;
      logic [7:0] ch;
      k = $urandom_range(NUM_KW - 1, 0);
      kind = $urandom_range(99, 0);
      if (kind < 85) begin
         n = $urandom_range(gen_len[k] + 1, 1);
      end else if (kind < 95) begin
         n = $urandom_range(5, 1);
      end else begin
         n = $urandom_range(KW_LEN + 4, KW_LEN - 1);
      end
      flip_at = (kind >= 70 && kind < 85) ? $urandom_range(n - 1, 0) : -1;
      for (i = 0; i < n; i++) begin
         if (kind >= 85 && kind < 95) begin
            ch = 8'($urandom);
         end else begin
            ch = (i < KW_LEN) ? gen_table[k][i] : 8'h00;
         end
         if (i == flip_at) begin
            ch ^= 8'(1 << $urandom_range(7, 0));
         end
         if ($urandom_range(99, 0) < 5) begin
            push_req(OP_LOAD, 4'($urandom), 5'($urandom), 8'($urandom), 1'($urandom));
         end
         push_req(OP_QUERY, 4'($urandom), 5'($urandom), ch, i == n - 1);
      end
   endtask

   int phase_counts[8] = '{16, 5, 31, 1, 16, 0, 12, 16};
   int phase_end;
   int ph;
   int s;

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.op = 1'b0;
      req_bus.keyword_slot = '0;
      req_bus.char_pos = '0;
      req_bus.char_value = '0;
      req_bus.is_last = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.keyword_count = '0;
      active_count = '0;
      pushed_count = 0;
      accepted_count = 0;
      error_count = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_asked = 0;
      hold_served = 0;
      hold_left = 0;
      cycle_count = 0;
      foreach (gen_table[i, j]) gen_table[i][j] = 8'h00;
      foreach (gen_len[i]) gen_len[i] = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_count(5'd16);
      push_req(OP_LOAD, 4'd0, 5'd0, 8'h41, 1'b0);
      push_req(OP_LOAD, 4'd0, 5'd1, 8'h42, 1'b1);
      push_req(OP_LOAD, 4'd15, 5'd0, 8'hFF, 1'b0);
      push_req(OP_LOAD, 4'd15, 5'd31, 8'hFF, 1'b1);
      push_req(OP_QUERY, 4'd0, 5'd0, 8'h41, 1'b0);
      // A load in the middle of a sequence must leave the sequence alone.
      push_req(OP_LOAD, 4'd3, 5'd0, 8'h5A, 1'b1);
      push_req(OP_QUERY, 4'd15, 5'd31, 8'h42, 1'b1);
      push_req(OP_QUERY, 4'd0, 5'd0, 8'h41, 1'b0);
      push_req(OP_QUERY, 4'd0, 5'd0, 8'h42, 1'b0);
      push_req(OP_QUERY, 4'd0, 5'd0, 8'h00, 1'b1);
      push_req(OP_QUERY, 4'd0, 5'd0, 8'hFF, 1'b1);
      push_req(OP_QUERY, 4'd0, 5'd0, 8'h00, 1'b1);
      push_req(OP_QUERY, 4'd0, 5'd0, 8'h5A, 1'b1);
      push_req(OP_QUERY, 4'd0, 5'd0, 8'h51, 1'b1);
      settle();
      write_count(5'd0);
      push_req(OP_QUERY, 4'd0, 5'd0, 8'h00, 1'b1);
      settle();
      write_count(5'd31);
      push_req(OP_QUERY, 4'd0, 5'd0, 8'hFF, 1'b1);
      settle();

      for (s = 0; s < NUM_KW; s++) begin
         queue_keyword(s);
      end
      for (ph = 0; ph < 8; ph++) begin
         settle();
         write_count(5'(phase_counts[ph]));
         case (ph % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 78;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 78;
            end
            default: begin
               send_idle_pct = 9;
               rsp_stall_pct = 9;
            end
         endcase
         phase_end = pushed_count + 210;
         while (pushed_count < phase_end) begin
            if ($urandom_range(99, 0) < 12) begin
               queue_keyword($urandom_range(NUM_KW - 1, 0));
            end else begin
               queue_query();
            end
         end
         if (ph == 3) begin
            // The receiver holds off while a burst of short sequences keeps coming.
            settle();
            send_idle_pct = 0;
            rsp_stall_pct = 0;
            hold_asked++;
            for (s = 0; s < 40; s++) begin
               push_req(OP_QUERY, 4'($urandom), 5'($urandom),
                        gen_table[$urandom_range(NUM_KW - 1, 0)][0], 1'b1);
            end
         end
      end

      settle();
      if (error_count == 0 && pending_matches.size() == 0) begin
         $display("PASS keyword_prefix_matcher");
      end else begin
         $display("FAIL keyword_prefix_matcher");
      end
      $finish;
   end

endmodule
